FILE: rtl/fqdv_pkg.sv
// ----------------------------------------------------------------------------
// fqdv_pkg: shared types for the handle queue with delete by value
// Transaction payloads, operation codes and the cell control bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fqdv_pkg;

   typedef enum logic [1:0] {
      MODE_ENQ  = 2'd0,
      MODE_DEQ  = 2'd1,
      MODE_DEL  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] removed_value;
      logic [4:0]  length;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic sample;
      logic commit;
      logic enq;
      logic del_chain;
   } cell_cmd_type;

   // where one cell stands relative to the fill level
   typedef struct packed {
      logic occupied;
      logic last;
      logic free;
   } cell_pos_type;

endpackage

FILE: rtl/fqdv_cell.sv
// ----------------------------------------------------------------------------
// fqdv_cell: one queue slot
// Holds one handle, compares it with the key and shifts towards the head
// when a removal at or before this slot ripples through the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fqdv_cell
   import fqdv_pkg::*;
#(
   parameter int HANDLE_WIDTH = 32
) (
   input  logic                    clock,
   input  cell_cmd_type            cmd,
   input  cell_pos_type            pos,
   input  logic [HANDLE_WIDTH-1:0] key,
   input  logic [HANDLE_WIDTH-1:0] next_data,
   input  logic                    kill_in,
   output logic                    kill_out,
   output logic [HANDLE_WIDTH-1:0] data,
   output logic                    hit,
   output logic                    tail_hit
);

   logic [HANDLE_WIDTH-1:0] data_ff;
   logic                    hit_ff;
   logic                    tail_hit_ff;
   logic                    shift;
   logic                    equal;

   assign equal    = (data_ff == key);
   assign shift    = kill_in || (cmd.del_chain && hit_ff);
   assign kill_out = shift;
   assign data     = data_ff;
   assign hit      = hit_ff;
   assign tail_hit = tail_hit_ff;

   always_ff @(posedge clock) begin
      if (cmd.sample) begin
         hit_ff      <= pos.occupied && equal;
         tail_hit_ff <= pos.occupied && pos.last && equal;
      end
      if (cmd.commit) begin
         if (shift) begin
            data_ff <= next_data;
         end else if (cmd.enq && pos.free) begin
            data_ff <= key;
         end
      end
   end

endmodule

FILE: rtl/fifo_queue_with_delete_by_value.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_by_value: bounded queue of nonzero handles
// Timing: an accepted request is registered as the state moves to ST_EXEC; the
// response strobe and payload are then registered out of ST_EXEC.
// Flow: the hit flags are sampled on acceptance and the cell chain commits in
// ST_EXEC; no new transaction is taken until ST_IDLE; the receiver cannot stall.
// Reset: synchronous; empties the queue, slot contents are left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_queue_with_delete_by_value
   import fqdv_pkg::*;
#(
   parameter int DEPTH        = 16,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type               state_ff;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   mode_type                op_ff;
   logic [HANDLE_WIDTH-1:0] value_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_payload_ff;

   logic                    accept;
   logic [HANDLE_WIDTH-1:0] req_key;
   logic [HANDLE_WIDTH-1:0] key;
   cell_cmd_type            cmd;
   logic                    ok;
   logic                    kill0;
   logic [31:0]             removed;

   logic [HANDLE_WIDTH-1:0] data_vec [DEPTH];
   logic [DEPTH-1:0]        hit_vec;
   logic [DEPTH-1:0]        tail_vec;
   logic [DEPTH:0]          kill_vec;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign req_key = HANDLE_WIDTH'(req_payload.value);
   assign key     = (state_ff == ST_EXEC) ? value_ff : req_key;
   assign kill_vec[0] = kill0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      cell_pos_type            pos;
      logic [HANDLE_WIDTH-1:0] next_data;

      assign pos.occupied = (IDX < count_ff);
      assign pos.last     = (IDX == (count_ff - CW'(1)));
      assign pos.free     = (IDX == count_ff);

      if (i < DEPTH - 1) begin : g_mid
         assign next_data = data_vec[i+1];
      end else begin : g_end
         assign next_data = '0;
      end

      fqdv_cell #(
         .HANDLE_WIDTH(HANDLE_WIDTH)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .pos      (pos),
         .key      (key),
         .next_data(next_data),
         .kill_in  (kill_vec[i]),
         .kill_out (kill_vec[i+1]),
         .data     (data_vec[i]),
         .hit      (hit_vec[i]),
         .tail_hit (tail_vec[i])
      );
   end

   always_comb begin
      ok            = 1'b0;
      kill0         = 1'b0;
      removed       = '0;
      count_in      = count_ff;
      cmd.sample    = accept;
      cmd.enq       = 1'b0;
      cmd.del_chain = 1'b0;
      unique case (op_ff)
         MODE_ENQ: begin
            if ((value_ff != '0) && (count_ff != FULL_COUNT)) begin
               ok       = 1'b1;
               cmd.enq  = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         MODE_DEQ: begin
            if (count_ff != '0) begin
               ok       = 1'b1;
               kill0    = 1'b1;
               removed  = 32'(data_vec[0]);
               count_in = count_ff - CW'(1);
            end
         end
         MODE_DEL: begin
            if ((value_ff != '0) && (|hit_vec)) begin
               ok            = 1'b1;
               cmd.del_chain = hit_vec[0] || !(|tail_vec);
               count_in      = count_ff - CW'(1);
            end
         end
         MODE_NONE: begin
            ok = 1'b0;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      cmd.commit = (state_ff == ST_EXEC) && ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff    <= req_payload.mode;
                  value_ff <= req_key;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               count_ff                     <= count_in;
               rsp_valid_ff                 <= 1'b1;
               rsp_payload_ff.status        <= !ok;
               rsp_payload_ff.removed_value <= removed;
               rsp_payload_ff.length        <= 5'(count_in);
               state_ff                     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_EXEC))
      else $error("response without an executed transaction");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill level beyond depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.status) |-> (count_ff == $past(count_ff)))
      else $error("rejected transaction changed the fill level");

endmodule

FILE: tb/sv/fqdv_checker.sv
// ----------------------------------------------------------------------------
// fqdv_checker: response checker for the handle queue with delete by value
// Watches both channels. It runs its own copy of the queue on every accepted
// request, holds the predicted responses in order and compares each strobed
// response with the oldest prediction. It reports the number of failures and
// of outstanding responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fqdv_checker
   import fqdv_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending
);

   logic [31:0] handles[$];
   rsp_type     predicted_rsp[$];
   rsp_type     oldest;

   // head first, then tail, then the earliest match in between
   function automatic rsp_type apply_queue_op(input req_type t);
      rsp_type r;
      int      idx;
      int      i;
      r.status        = 1'b1;
      r.removed_value = '0;
      idx             = -1;
      case (t.mode)
         MODE_ENQ: begin
            if (t.value != 0 && handles.size() < DEPTH) begin
               handles.push_back(t.value);
               r.status = 1'b0;
            end
         end
         MODE_DEQ: begin
            if (handles.size() > 0) begin
               r.removed_value = handles.pop_front();
               r.status        = 1'b0;
            end
         end
         MODE_DEL: begin
            if (t.value != 0 && handles.size() > 0) begin
               if (handles[0] == t.value) begin
                  idx = 0;
               end else if (handles[handles.size() - 1] == t.value) begin
                  idx = handles.size() - 1;
               end else begin
                  for (i = 1; i + 1 < handles.size() && idx < 0; i++) begin
                     if (handles[i] == t.value) begin
                        idx = i;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      if (idx >= 0) begin
         handles.delete(idx);
         r.status = 1'b0;
      end
      r.length = 5'(handles.size());
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         handles.delete();
         predicted_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (predicted_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response status %0d removed %h length %0d",
                        $time, rsp_payload.status, rsp_payload.removed_value,
                        rsp_payload.length);
            end else begin
               oldest = predicted_rsp.pop_front();
               if (rsp_payload !== oldest) begin
                  fail_count++;
                  $display("%0t: expected status %0d removed %h length %0d, got status %0d removed %h length %0d",
                           $time, oldest.status, oldest.removed_value, oldest.length,
                           rsp_payload.status, rsp_payload.removed_value,
                           rsp_payload.length);
               end
            end
         end
         if (start && !busy) begin
            predicted_rsp.push_back(apply_queue_op(req_payload));
         end
      end
      pending = predicted_rsp.size();
   end

endmodule

FILE: tb/sv/fifo_queue_with_delete_by_value_test.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_by_value_test: testbench top for the handle queue
// Drives a directed run through the null, empty, full, no-match, sole-entry,
// head, tail and middle delete cases and the unused mode, then random
// transactions that swing the queue between empty and full over a small pool
// of handles so that deletes find matches. A checker beside the block predicts
// and compares; a watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_queue_with_delete_by_value_test;
   import fqdv_pkg::*;

   localparam int DEPTH      = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam int RAND_OPS   = 1200;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_valid;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending;
   int      idle_cycles;

   fifo_queue_with_delete_by_value #(
      .DEPTH        (DEPTH),
      .HANDLE_WIDTH (32)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   fqdv_checker #(
      .DEPTH (DEPTH)
   ) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      idle_cycles = 0;
   end

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // drop start over the gap with a random payload, then present the transaction until accepted
   task automatic issue(input mode_type m, input logic [31:0] v, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         req_payload = {mode_type'($urandom_range(3)), 32'($urandom)};
         repeat (gap) @(negedge clock);
      end
      start             = 1'b1;
      req_payload.mode  = m;
      req_payload.value = v;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int          n;
      int          r;
      int          gap;
      bit          filling;
      mode_type    m;
      logic [31:0] v;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      issue(MODE_ENQ, 32'h0, 0);
      issue(MODE_DEQ, 32'h0, 0);
      issue(MODE_DEL, 32'h7, 0);
      issue(MODE_NONE, 32'hFFFF_FFFF, 0);
      issue(MODE_ENQ, 32'hFFFF_FFFF, 0);
      issue(MODE_DEL, 32'h0, 0);
      issue(MODE_DEL, 32'h12, 0);
      issue(MODE_DEL, 32'hFFFF_FFFF, 0);
      for (n = 0; n < DEPTH; n++) begin
         issue(MODE_ENQ, 32'(n % 5 + 1), 0);
      end
      issue(MODE_ENQ, 32'h9, 0);
      issue(MODE_DEL, 32'h1, 0);
      issue(MODE_DEL, 32'h1, 0);
      issue(MODE_DEL, 32'h3, 0);
      issue(MODE_DEL, 32'h5, 0);
      issue(MODE_DEQ, 32'h0, 1);
      drain();

      for (n = 0; n < RAND_OPS; n++) begin
         filling = ((n / 60) % 2) == 0;
         r = $urandom_range(99);
         if (r < 5) begin
            m = MODE_NONE;
         end else if (filling) begin
            m = (r < 72) ? MODE_ENQ : (r < 87) ? MODE_DEL : MODE_DEQ;
         end else begin
            m = (r < 25) ? MODE_ENQ : (r < 62) ? MODE_DEL : MODE_DEQ;
         end
         r = $urandom_range(99);
         if (r < 10) begin
            v = '0;
         end else if (r < 75) begin
            v = 32'($urandom_range(6, 1));
         end else begin
            v = $urandom;
         end
         gap = 0;
         if ((n % 250) >= 40) begin
            r = $urandom_range(99);
            if (r >= 95) begin
               gap = $urandom_range(40, 8);
            end else if (r >= 65) begin
               gap = $urandom_range(3, 1);
            end
         end
         if (n == RAND_OPS / 2) begin
            drain();
         end
         issue(m, v, gap);
      end

      drain();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: fifo_queue_with_delete_by_value.f
rtl/fqdv_pkg.sv
rtl/fqdv_cell.sv
rtl/fifo_queue_with_delete_by_value.sv
tb/sv/fqdv_checker.sv
tb/sv/fifo_queue_with_delete_by_value_test.sv
